/* sv/ptzfe_pkg.sv */
// ----------------------------------------------------------------------------
// Pan/tilt/zoom frame encoder package
// Shared types, register indexes, opcodes, command codes and the speed scaling.
// ----------------------------------------------------------------------------
package ptzfe_pkg;

	localparam int unsigned FRAME_LEN = 7;
	localparam int unsigned HOLD_DEPTH = FRAME_LEN - 1;
	localparam int unsigned POS_W = $clog2(FRAME_LEN);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);
	localparam int unsigned QUEUE_DEPTH_DEF = 2;
	localparam int unsigned CFG_ADDR_W = 4;

	localparam logic [7:0] SYNC_BYTE = 8'hFF;
	localparam logic [7:0] ADDRESS_RESET = 8'd1;
	localparam logic [6:0] SPEED_RESET = 7'd50;

	// 2^19 / 100 rounded up; exact for every product 63 * percent below 2^14.
	localparam logic [12:0] SPEED_RECIP = 13'd5243;
	localparam int unsigned SPEED_SHIFT = 19;

	typedef enum logic [1:0] {
		REG_CAMERA_ADDRESS,
		REG_DEFAULT_SPEED,
		REG_AUTO_FOCUS_ON,
		REG_AUTO_IRIS_ON
	} reg_index_t;

	localparam logic [4:0] OP_STOP        = 5'd0;
	localparam logic [4:0] OP_LEFT        = 5'd1;
	localparam logic [4:0] OP_RIGHT       = 5'd2;
	localparam logic [4:0] OP_UP          = 5'd3;
	localparam logic [4:0] OP_DOWN        = 5'd4;
	localparam logic [4:0] OP_LEFT_UP     = 5'd5;
	localparam logic [4:0] OP_LEFT_DOWN   = 5'd6;
	localparam logic [4:0] OP_RIGHT_UP    = 5'd7;
	localparam logic [4:0] OP_RIGHT_DOWN  = 5'd8;
	localparam logic [4:0] OP_ZOOM_TELE   = 5'd9;
	localparam logic [4:0] OP_ZOOM_WIDE   = 5'd10;
	localparam logic [4:0] OP_IRIS_OPEN   = 5'd11;
	localparam logic [4:0] OP_IRIS_CLOSE  = 5'd12;
	localparam logic [4:0] OP_FOCUS_NEAR  = 5'd13;
	localparam logic [4:0] OP_FOCUS_FAR   = 5'd14;
	localparam logic [4:0] OP_SET_PRESET  = 5'd15;
	localparam logic [4:0] OP_GOTO_PRESET = 5'd16;
	localparam logic [4:0] OP_AUTO_FOCUS  = 5'd17;
	localparam logic [4:0] OP_AUTO_IRIS   = 5'd18;

	localparam logic [7:0] CMD2_LEFT        = 8'h04;
	localparam logic [7:0] CMD2_RIGHT       = 8'h02;
	localparam logic [7:0] CMD2_UP          = 8'h08;
	localparam logic [7:0] CMD2_DOWN        = 8'h10;
	localparam logic [7:0] CMD2_LEFT_UP     = 8'h0C;
	localparam logic [7:0] CMD2_LEFT_DOWN   = 8'h14;
	localparam logic [7:0] CMD2_RIGHT_UP    = 8'h0A;
	localparam logic [7:0] CMD2_RIGHT_DOWN  = 8'h12;
	localparam logic [7:0] CMD2_ZOOM_TELE   = 8'h20;
	localparam logic [7:0] CMD2_ZOOM_WIDE   = 8'h40;
	localparam logic [7:0] CMD1_IRIS_OPEN   = 8'h02;
	localparam logic [7:0] CMD1_IRIS_CLOSE  = 8'h04;
	localparam logic [7:0] CMD1_FOCUS_NEAR  = 8'h01;
	localparam logic [7:0] CMD2_FOCUS_FAR   = 8'h80;
	localparam logic [7:0] CMD2_SET_PRESET  = 8'h03;
	localparam logic [7:0] CMD2_GOTO_PRESET = 8'h07;
	localparam logic [7:0] CMD2_AUTO_FOCUS  = 8'h2B;
	localparam logic [7:0] CMD2_AUTO_IRIS   = 8'h2D;
	localparam logic [7:0] AUTO_MODE_ON     = 8'h00;
	localparam logic [7:0] AUTO_MODE_OFF    = 8'h02;

	typedef struct packed {
		logic [7:0] camera_address;
		logic [6:0] default_speed;
		logic       auto_focus_on;
		logic       auto_iris_on;
	} cfg_t;

	typedef struct packed {
		logic [7:0] address;
		logic [7:0] cmd1;
		logic [7:0] cmd2;
		logic [7:0] data1;
		logic [7:0] data2;
		logic [7:0] checksum;
	} frame_rec_t;

	typedef struct packed {
		logic             busy;
		logic [POS_W-1:0] pos;
	} back_status_t;

	// Divides 63 * percent by 100 through the reciprocal; the result is truncated.
	function automatic logic [7:0] speed_of(input logic [13:0] scaled);
		logic [26:0] prod;
		prod = 27'(scaled) * 27'(SPEED_RECIP);
		return prod[SPEED_SHIFT +: 8];
	endfunction

endpackage

/* sv/ptzfe_front.sv */
// ----------------------------------------------------------------------------
// Frame encoder front end
// Takes commands, scales the speed and builds the frame record with checksum.
// ----------------------------------------------------------------------------
module ptzfe_front import ptzfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       push,
	output logic       full,
	input  logic [4:0] opcode,
	input  logic [7:0] command_param,
	output logic       rec_push,
	output frame_rec_t rec,
	input  logic       rec_ready
);

	logic        valid_s1;
	logic [4:0]  opcode_s1;
	logic [7:0]  param_s1;
	logic [13:0] scaled_s1;
	logic        accept;
	logic [7:0]  percent;
	logic [7:0]  spd;
	frame_rec_t  rec_c;

	assign full   = valid_s1 && !rec_ready;
	assign accept = push && !full;
	assign percent = (command_param != 8'd0) ? command_param : {1'b0, cfg.default_speed};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (rec_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// 63 * percent as a shift and a subtract.
	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1 <= opcode;
			param_s1  <= command_param;
			scaled_s1 <= {percent, 6'b0} - {6'b0, percent};
		end
	end

	assign spd = speed_of(scaled_s1);

	always_comb begin
		rec_c = '0;
		rec_c.address = cfg.camera_address;
		case (opcode_s1)
			OP_LEFT: begin
				rec_c.cmd2 = CMD2_LEFT; rec_c.data1 = spd;
			end
			OP_RIGHT: begin
				rec_c.cmd2 = CMD2_RIGHT; rec_c.data1 = spd;
			end
			OP_UP: begin
				rec_c.cmd2 = CMD2_UP; rec_c.data2 = spd;
			end
			OP_DOWN: begin
				rec_c.cmd2 = CMD2_DOWN; rec_c.data2 = spd;
			end
			OP_LEFT_UP: begin
				rec_c.cmd2 = CMD2_LEFT_UP; rec_c.data1 = spd; rec_c.data2 = spd;
			end
			OP_LEFT_DOWN: begin
				rec_c.cmd2 = CMD2_LEFT_DOWN; rec_c.data1 = spd; rec_c.data2 = spd;
			end
			OP_RIGHT_UP: begin
				rec_c.cmd2 = CMD2_RIGHT_UP; rec_c.data1 = spd; rec_c.data2 = spd;
			end
			OP_RIGHT_DOWN: begin
				rec_c.cmd2 = CMD2_RIGHT_DOWN; rec_c.data1 = spd; rec_c.data2 = spd;
			end
			OP_ZOOM_TELE:  rec_c.cmd2 = CMD2_ZOOM_TELE;
			OP_ZOOM_WIDE:  rec_c.cmd2 = CMD2_ZOOM_WIDE;
			OP_IRIS_OPEN:  rec_c.cmd1 = CMD1_IRIS_OPEN;
			OP_IRIS_CLOSE: rec_c.cmd1 = CMD1_IRIS_CLOSE;
			OP_FOCUS_NEAR: rec_c.cmd1 = CMD1_FOCUS_NEAR;
			OP_FOCUS_FAR:  rec_c.cmd2 = CMD2_FOCUS_FAR;
			OP_SET_PRESET: begin
				rec_c.cmd2 = CMD2_SET_PRESET; rec_c.data2 = param_s1;
			end
			OP_GOTO_PRESET: begin
				rec_c.cmd2 = CMD2_GOTO_PRESET; rec_c.data2 = param_s1;
			end
			OP_AUTO_FOCUS: begin
				rec_c.cmd2  = CMD2_AUTO_FOCUS;
				rec_c.data2 = cfg.auto_focus_on ? AUTO_MODE_ON : AUTO_MODE_OFF;
			end
			OP_AUTO_IRIS: begin
				rec_c.cmd2  = CMD2_AUTO_IRIS;
				rec_c.data2 = cfg.auto_iris_on ? AUTO_MODE_ON : AUTO_MODE_OFF;
			end
			default: ;
		endcase
		rec_c.checksum = rec_c.address + rec_c.cmd1 + rec_c.cmd2 + rec_c.data1 + rec_c.data2;
	end

	assign rec_push = valid_s1 && rec_ready;
	assign rec      = rec_c;

endmodule

/* sv/ptzfe_queue.sv */
// ----------------------------------------------------------------------------
// Frame record queue
// Small first-in first-out store between the front end and the serialiser.
// ----------------------------------------------------------------------------
module ptzfe_queue import ptzfe_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  frame_rec_t                 rec_in,
	output logic                       ready,
	input  logic                       pop,
	output frame_rec_t                 rec_out,
	output logic                       valid,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	frame_rec_t       slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign ready   = count_q != CNT_FULL;
	assign valid   = count_q != '0;
	assign do_push = push && ready;
	assign do_pop  = pop && valid;
	assign rec_out = slot_q[rd_ptr_q];
	assign count   = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= rec_in;
		end
	end

endmodule

/* sv/ptzfe_back.sv */
// ----------------------------------------------------------------------------
// Frame serialiser
// Holds one frame and sends it a byte per beat through an output register.
// ----------------------------------------------------------------------------
module ptzfe_back import ptzfe_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         rec_valid,
	input  frame_rec_t   rec,
	output logic         rec_pop,
	output logic         empty,
	input  logic         pop,
	output logic [7:0]   frame_byte,
	output logic         last_byte,
	output back_status_t status
);

	logic [7:0]       frame_hold_q [HOLD_DEPTH];
	logic [7:0]       checksum_q;
	logic             cur_valid_q;
	logic [POS_W-1:0] pos_q;
	logic             out_valid_q;
	logic [7:0]       byte_q;
	logic             last_q;
	logic             advance;
	logic             frame_end;
	logic             load;

	assign advance   = !out_valid_q || pop;
	assign frame_end = cur_valid_q && (pos_q == LAST_POS);
	// The next frame is taken in as the checksum of this one moves out.
	assign load      = rec_valid && (!cur_valid_q || (advance && frame_end));
	assign rec_pop   = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				cur_valid_q <= 1'b1;
			end else if (advance && frame_end) begin
				cur_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= cur_valid_q;
				if (cur_valid_q) begin
					pos_q <= frame_end ? '0 : pos_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && cur_valid_q) begin
			byte_q <= frame_end ? checksum_q : frame_hold_q[pos_q];
			last_q <= frame_end;
		end
		if (load) begin
			frame_hold_q[0] <= SYNC_BYTE;
			frame_hold_q[1] <= rec.address;
			frame_hold_q[2] <= rec.cmd1;
			frame_hold_q[3] <= rec.cmd2;
			frame_hold_q[4] <= rec.data1;
			frame_hold_q[5] <= rec.data2;
			checksum_q      <= rec.checksum;
		end
	end

	assign empty       = !out_valid_q;
	assign frame_byte  = byte_q;
	assign last_byte   = last_q;
	assign status.busy = cur_valid_q;
	assign status.pos  = pos_q;

endmodule

/* sv/pan_tilt_zoom_frame_encoder.sv */
// ----------------------------------------------------------------------------
// Pan/tilt/zoom command frame encoder
// Turns camera commands into seven-byte Pelco-D frames, sent a byte per beat.
// ----------------------------------------------------------------------------
// Each command pushed in (opcode and an 8-bit parameter) comes out as seven
// result beats: 0xFF, the camera address, command byte 1, command byte 2,
// data 1, data 2 and the checksum, the last of these flagged by last_byte.
// The checksum is the modulo-256 sum of the five bytes after the sync byte.
// Motion speed is 63 * percent / 100, truncated and not clamped, where the
// percent is the parameter, or the default_speed register when the parameter
// is zero. Preset commands copy the parameter into data 2; auto focus and
// auto iris send 0x00 or 0x02 according to their register flags; stop and
// unknown opcodes send all-zero command and data bytes. The front end
// registers each command taken and builds its frame record in the next
// cycle; records wait in a short queue, and the serialiser sends one byte per
// cycle from its output register while the receiver pops, taking in the next
// frame as the checksum of the last moves out. When the block is idle, a
// command passes the front-end input stage, the queue, the frame hold and the
// output register before its first byte appears. The front end keeps accepting
// while earlier frames are still being sent, until the queue and its input stage
// are full. There is no clearing pass after reset. Registers (APB, byte
// addresses): 0x0 camera address, 0x4 default speed, 0x8 auto focus flag, 0xC
// auto iris flag; they should only be written while no frame is in flight.
module pan_tilt_zoom_frame_encoder import ptzfe_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  push,
	output logic                  full,
	input  logic [4:0]            opcode,
	input  logic [7:0]            command_param,
	output logic                  empty,
	input  logic                  pop,
	output logic [7:0]            frame_byte,
	output logic                  last_byte
);

	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	cfg_t         cfg_q;
	reg_index_t   reg_index;
	logic         cfg_write;
	logic         rec_push;
	logic         rec_ready;
	frame_rec_t   rec_in;
	frame_rec_t   rec_out;
	logic         rec_valid;
	logic         rec_pop;
	logic [CNT_W-1:0] q_count;
	back_status_t back_status;

	// Configuration port: no wait states, registers decoded on the word address.
	assign pready    = 1'b1;
	assign reg_index = reg_index_t'(paddr[CFG_ADDR_W-1:2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.camera_address <= ADDRESS_RESET;
			cfg_q.default_speed  <= SPEED_RESET;
			cfg_q.auto_focus_on  <= 1'b1;
			cfg_q.auto_iris_on   <= 1'b1;
		end else if (cfg_write) begin
			case (reg_index)
				REG_CAMERA_ADDRESS: cfg_q.camera_address <= pwdata[7:0];
				REG_DEFAULT_SPEED:  cfg_q.default_speed  <= pwdata[6:0];
				REG_AUTO_FOCUS_ON:  cfg_q.auto_focus_on  <= pwdata[0];
				REG_AUTO_IRIS_ON:   cfg_q.auto_iris_on   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_index)
			REG_CAMERA_ADDRESS: prdata = {24'b0, cfg_q.camera_address};
			REG_DEFAULT_SPEED:  prdata = {25'b0, cfg_q.default_speed};
			REG_AUTO_FOCUS_ON:  prdata = {31'b0, cfg_q.auto_focus_on};
			REG_AUTO_IRIS_ON:   prdata = {31'b0, cfg_q.auto_iris_on};
			default:            prdata = '0;
		endcase
	end

	// Front end: accepts a command, scales the speed and assembles the record.
	ptzfe_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.push          (push),
		.full          (full),
		.opcode        (opcode),
		.command_param (command_param),
		.rec_push      (rec_push),
		.rec           (rec_in),
		.rec_ready     (rec_ready)
	);

	// Queue of finished records, so that either side may stall on its own.
	ptzfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (rec_push),
		.rec_in  (rec_in),
		.ready   (rec_ready),
		.pop     (rec_pop),
		.rec_out (rec_out),
		.valid   (rec_valid),
		.count   (q_count)
	);

	// Serialiser: one byte per beat, last_byte on the checksum.
	ptzfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.rec_valid  (rec_valid),
		.rec        (rec_out),
		.rec_pop    (rec_pop),
		.empty      (empty),
		.pop        (pop),
		.frame_byte (frame_byte),
		.last_byte  (last_byte),
		.status     (back_status)
	);

	// After a frame's checksum is taken, the next byte shown must open a frame.
	a_sync_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && last_byte) |=> (empty || frame_byte == SYNC_BYTE))
		else $error("frame does not open with the sync byte");

	// The front end only holds off a command when the queue has no room.
	a_full_means_queue_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> (q_count == CNT_W'(QUEUE_DEPTH)))
		else $error("front end stalled while the queue had room");

	// The serialiser never runs past the checksum position.
	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		back_status.pos <= LAST_POS)
		else $error("byte position beyond the frame");

	// A frame is taken from the queue only when the queue has one.
	a_pop_has_record: assert property (@(posedge clk) disable iff (!arst_n)
		rec_pop |-> (q_count != '0))
		else $error("serialiser took a record from an empty queue");

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// Pan/tilt/zoom frame encoder testbench
// Pushes camera commands, predicts each seven-byte frame and checks every beat.
// ----------------------------------------------------------------------------
// A directed burst comes first. It covers every opcode, the first and last
// unused opcodes, parameter extremes and preset numbers, all under the reset register values.
// Random phases follow, each under its own register setting: all zero, all at
// the top of their width, and random mixes. Each phase also has its own mix of
// sender gaps and receiver stalls. In one phase the receiver holds off for a
// long stretch so that the block fills up and raises full. Registers are
// changed only once every expected beat has arrived, and each write is read
// back. A watchdog ends the run if no beat moves on either side for too long.
module tb_top;
	import ptzfe_pkg::*;

	// Opcodes above the last defined one send an all-zero command.
	localparam logic [4:0] OP_UNUSED_FIRST = 5'd19;
	localparam logic [4:0] OP_UNUSED_LAST = 5'd31;
	localparam int RANDOM_PER_PHASE = 52;
	localparam int HOLD_CYCLES = 150;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic [4:0] op;
		logic [7:0] param;
	} command_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_beat_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;
	logic                  push = 1'b0;
	logic                  full;
	logic [4:0]            opcode = '0;
	logic [7:0]            command_param = '0;
	logic                  empty;
	logic                  pop = 1'b0;
	logic [7:0]            frame_byte;
	logic                  last_byte;

	// Commands waiting to be offered, and frame bytes still owed by the block.
	command_t    commands_pending[$];
	frame_beat_t frame_beats_due[$];

	// Our own copy of the register file, updated as each write goes in.
	logic [7:0] cam_address = ADDRESS_RESET;
	logic [6:0] dflt_speed = SPEED_RESET;
	logic       af_on = 1'b1;
	logic       ai_on = 1'b1;

	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	logic push_hit = 1'b0;
	logic hold_req = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;

	int commands_sent = 0;
	int beats_checked = 0;
	int full_cycles = 0;
	int settings_used = 1;
	int mismatches = 0;

	pan_tilt_zoom_frame_encoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.push(push),
		.full(full),
		.opcode(opcode),
		.command_param(command_param),
		.empty(empty),
		.pop(pop),
		.frame_byte(frame_byte),
		.last_byte(last_byte)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got 0x%0h, expected 0x%0h (beat %0d)", what, got, want,
			beats_checked);
		mismatches++;
	endtask

	// Speed is 63 * percent / 100, truncated to eight bits but never clamped.
	function automatic logic [7:0] speed_pct(input logic [7:0] pct);
		int unsigned scaled;
		scaled = 63 * int'(pct) / 100;
		return 8'(scaled);
	endfunction

	// Works out the frame for one command and queues its seven bytes.
	task automatic build_frame(input command_t cmd);
		logic [7:0] spd, c1, c2, d1, d2, sum;
		spd = speed_pct(cmd.param != 8'd0 ? cmd.param : {1'b0, dflt_speed});
		c1 = 8'h00;
		c2 = 8'h00;
		d1 = 8'h00;
		d2 = 8'h00;
		case (cmd.op)
			OP_LEFT: begin
				c2 = CMD2_LEFT;
				d1 = spd;
			end
			OP_RIGHT: begin
				c2 = CMD2_RIGHT;
				d1 = spd;
			end
			OP_UP: begin
				c2 = CMD2_UP;
				d2 = spd;
			end
			OP_DOWN: begin
				c2 = CMD2_DOWN;
				d2 = spd;
			end
			OP_LEFT_UP: begin
				c2 = CMD2_LEFT_UP;
				d1 = spd;
				d2 = spd;
			end
			OP_LEFT_DOWN: begin
				c2 = CMD2_LEFT_DOWN;
				d1 = spd;
				d2 = spd;
			end
			OP_RIGHT_UP: begin
				c2 = CMD2_RIGHT_UP;
				d1 = spd;
				d2 = spd;
			end
			OP_RIGHT_DOWN: begin
				c2 = CMD2_RIGHT_DOWN;
				d1 = spd;
				d2 = spd;
			end
			OP_ZOOM_TELE: c2 = CMD2_ZOOM_TELE;
			OP_ZOOM_WIDE: c2 = CMD2_ZOOM_WIDE;
			OP_IRIS_OPEN: c1 = CMD1_IRIS_OPEN;
			OP_IRIS_CLOSE: c1 = CMD1_IRIS_CLOSE;
			OP_FOCUS_NEAR: c1 = CMD1_FOCUS_NEAR;
			OP_FOCUS_FAR: c2 = CMD2_FOCUS_FAR;
			OP_SET_PRESET: begin
				c2 = CMD2_SET_PRESET;
				d2 = cmd.param;
			end
			OP_GOTO_PRESET: begin
				c2 = CMD2_GOTO_PRESET;
				d2 = cmd.param;
			end
			OP_AUTO_FOCUS: begin
				c2 = CMD2_AUTO_FOCUS;
				d2 = af_on ? AUTO_MODE_ON : AUTO_MODE_OFF;
			end
			OP_AUTO_IRIS: begin
				c2 = CMD2_AUTO_IRIS;
				d2 = ai_on ? AUTO_MODE_ON : AUTO_MODE_OFF;
			end
			default: ;
		endcase
		// Eight-bit arithmetic gives the modulo-256 sum directly.
		sum = cam_address + c1 + c2 + d1 + d2;
		frame_beats_due.push_back('{SYNC_BYTE, 1'b0});
		frame_beats_due.push_back('{cam_address, 1'b0});
		frame_beats_due.push_back('{c1, 1'b0});
		frame_beats_due.push_back('{c2, 1'b0});
		frame_beats_due.push_back('{d1, 1'b0});
		frame_beats_due.push_back('{d2, 1'b0});
		frame_beats_due.push_back('{sum, 1'b1});
	endtask

	// One APB write followed by a read back of the same register. Bits above
	// the register's width are dropped by the block, so the shadow copy and
	// the read-back value are masked in the same way.
	task automatic write_reg(input reg_index_t idx, input logic [31:0] value,
			input logic [31:0] mask);
		logic [31:0] got;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_ADDR_W'(int'(idx) * 4);
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== (value & mask))
			report_mismatch("register read back", got, value & mask);
		case (idx)
			REG_CAMERA_ADDRESS: cam_address = value[7:0];
			REG_DEFAULT_SPEED: dflt_speed = value[6:0];
			REG_AUTO_FOCUS_ON: af_on = value[0];
			REG_AUTO_IRIS_ON: ai_on = value[0];
			default: ;
		endcase
	endtask

	// Writes all four registers. With junk set, the unused upper bits of the
	// data bus carry random values, which the block must ignore.
	task automatic set_all_regs(input logic [7:0] addr, input logic [6:0] spd,
			input logic af, input logic ai, input bit junk);
		logic [31:0] noise;
		noise = junk ? $urandom : 32'd0;
		write_reg(REG_CAMERA_ADDRESS, {noise[31:8], addr}, 32'h0000_00FF);
		write_reg(REG_DEFAULT_SPEED, {noise[31:7], spd}, 32'h0000_007F);
		write_reg(REG_AUTO_FOCUS_ON, {noise[31:1], af}, 32'h0000_0001);
		write_reg(REG_AUTO_IRIS_ON, {noise[31:1], ai}, 32'h0000_0001);
		settings_used++;
	endtask

	// Returns once every command has gone in and every frame byte has come
	// out, then leaves a few cycles so that the block is fully at rest.
	task automatic wait_drained();
		while (commands_pending.size() != 0 || frame_beats_due.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic run_random_phase(input int n, input int idle_pct, input int stall_pct);
		command_t cmd;
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		repeat (n) begin
			// Mostly defined opcodes, with the unused range mixed in.
			if ($urandom_range(99) < 85)
				cmd.op = 5'($urandom_range(OP_AUTO_IRIS));
			else
				cmd.op = 5'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
			// Zero selects the default speed; 100, 101 and 255 sit at the edges.
			case ($urandom_range(9))
				0, 1: cmd.param = 8'd0;
				2: cmd.param = 8'd255;
				3: cmd.param = 8'd100;
				4: cmd.param = 8'd101;
				default: cmd.param = 8'($urandom_range(255));
			endcase
			commands_pending.push_back(cmd);
		end
		wait_drained();
	endtask

	// Input side: a command is taken at an edge where push is high and full
	// is low. Its frame is predicted there, under the register values now set.
	always @(posedge clk) begin
		push_hit <= arst_n && push && !full;
		if (arst_n && push && !full) begin
			build_frame(commands_pending.pop_front());
			commands_sent++;
		end
		if (arst_n && push && full)
			full_cycles++;
	end

	// Driver. An offer that has not been taken stays on the bus unchanged.
	// Otherwise the next command is offered unless this cycle is a gap. The
	// data bus carries noise while push is low.
	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (!(push && !push_hit)) begin
			if (commands_pending.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				push <= 1'b1;
				opcode <= commands_pending[0].op;
				command_param <= commands_pending[0].param;
			end else begin
				push <= 1'b0;
				opcode <= 5'($urandom);
				command_param <= 8'($urandom);
			end
		end
	end

	// Long receiver hold-off, counted here in a process of its own.
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left <= HOLD_CYCLES;
			hold_req <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(negedge clk)
		pop <= arst_n && hold_left == 0 && $urandom_range(99) >= receiver_stall_pct;

	// Monitor: each frame byte taken is compared with the oldest prediction.
	always @(posedge clk) begin
		frame_beat_t want;
		if (arst_n && pop && !empty) begin
			if (frame_beats_due.size() == 0) begin
				report_mismatch("frame byte with nothing expected", 32'(frame_byte), 32'd0);
			end else begin
				want = frame_beats_due.pop_front();
				if (frame_byte !== want.data)
					report_mismatch("frame_byte", 32'(frame_byte), 32'(want.data));
				if (last_byte !== want.last)
					report_mismatch("last_byte", 32'(last_byte), 32'(want.last));
			end
			beats_checked++;
		end
	end

	// Watchdog: too long without a beat on either side means the block hung.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no beat for %0d cycles, %0d bytes still due",
				quiet_cycles, frame_beats_due.size());
			$display("pan_tilt_zoom_frame_encoder test failed");
			$finish;
		end
	end

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed burst under the reset registers: every opcode, both ends of the unused
		// range, and the parameter edges (zero for the default speed, one, the
		// top of the percent range, just above it, and 255, which is not clamped).
		commands_pending.push_back('{OP_STOP, 8'd0});
		commands_pending.push_back('{OP_LEFT, 8'd0});
		commands_pending.push_back('{OP_RIGHT, 8'd255});
		commands_pending.push_back('{OP_UP, 8'd1});
		commands_pending.push_back('{OP_DOWN, 8'd100});
		commands_pending.push_back('{OP_LEFT_UP, 8'd101});
		commands_pending.push_back('{OP_LEFT_DOWN, 8'd128});
		commands_pending.push_back('{OP_RIGHT_UP, 8'd127});
		commands_pending.push_back('{OP_RIGHT_DOWN, 8'd2});
		commands_pending.push_back('{OP_ZOOM_TELE, 8'd255});
		commands_pending.push_back('{OP_ZOOM_WIDE, 8'd0});
		commands_pending.push_back('{OP_IRIS_OPEN, 8'd85});
		commands_pending.push_back('{OP_IRIS_CLOSE, 8'd170});
		commands_pending.push_back('{OP_FOCUS_NEAR, 8'd255});
		commands_pending.push_back('{OP_FOCUS_FAR, 8'd0});
		commands_pending.push_back('{OP_SET_PRESET, 8'd0});
		commands_pending.push_back('{OP_SET_PRESET, 8'd255});
		commands_pending.push_back('{OP_GOTO_PRESET, 8'd1});
		commands_pending.push_back('{OP_GOTO_PRESET, 8'd254});
		commands_pending.push_back('{OP_AUTO_FOCUS, 8'd0});
		commands_pending.push_back('{OP_AUTO_IRIS, 8'd255});
		commands_pending.push_back('{OP_UNUSED_FIRST, 8'd77});
		commands_pending.push_back('{OP_UNUSED_LAST, 8'd255});
		commands_pending.push_back('{OP_STOP, 8'd255});
		wait_drained();

		// Every register at zero: address 0, default speed 0, both autos off.
		// The sender leaves gaps in most cycles.
		set_all_regs(8'd0, 7'd0, 1'b0, 1'b0, 1'b0);
		run_random_phase(RANDOM_PER_PHASE, 63, 0);

		// Every register at the top of its width, written with junk in the
		// upper bus bits. The receiver stalls often and at first holds off
		// completely, so the block fills up and pushes back on the sender.
		set_all_regs(8'd255, 7'd127, 1'b1, 1'b1, 1'b1);
		hold_req = 1'b1;
		run_random_phase(RANDOM_PER_PHASE, 0, 63);

		// Highest legal default speed with a random address and random flags,
		// gaps and stalls on both sides.
		set_all_regs(8'($urandom), 7'd100, 1'($urandom), 1'($urandom), 1'b1);
		run_random_phase(RANDOM_PER_PHASE, 33, 33);

		// Fully random setting, run flat out.
		set_all_regs(8'($urandom), 7'($urandom_range(127)), 1'($urandom), 1'($urandom), 1'b0);
		run_random_phase(RANDOM_PER_PHASE, 0, 0);

		repeat (8) @(negedge clk);
		$display("Sent %0d commands and checked %0d frame bytes over %0d register settings.",
			commands_sent, beats_checked, settings_used);
		$display("Input was held back by full for %0d cycles; %0d mismatches seen.",
			full_cycles, mismatches);
		if (mismatches == 0 && frame_beats_due.size() == 0)
			$display("pan_tilt_zoom_frame_encoder test passed");
		else
			$display("pan_tilt_zoom_frame_encoder test failed");
		$finish;
	end

endmodule

/* sim.f */
sv/ptzfe_pkg.sv
sv/ptzfe_front.sv
sv/ptzfe_queue.sv
sv/ptzfe_back.sv
sv/pan_tilt_zoom_frame_encoder.sv
test/tb_top.sv
